/* rtl/core/r2h_pkg.sv */
// r2h_pkg: widths, constants and pipeline stage types of the rgb to hsv converter
// no dependencies; imported by the channel interfaces, the core and the checker
`default_nettype none

package r2h_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned HueW   = 13;
  localparam int unsigned HueQW  = 10;
  localparam int unsigned HueNW  = 18;
  localparam int unsigned SatQW  = 8;
  localparam int unsigned SatNW  = 16;

  localparam int unsigned HueScale = 960;
  localparam int unsigned ChanFull = 255;

  localparam logic [HueW-1:0] HueRedOffset   = 13'd0;
  localparam logic [HueW-1:0] HueGreenOffset = 13'd1920;
  localparam logic [HueW-1:0] HueBlueOffset  = 13'd3840;
  localparam logic [HueW-1:0] HueFullTurn    = 13'd5760;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [HueW-1:0]  hue_t;

  typedef enum logic [2:0] {
    SecRed   = 3'b001,
    SecGreen = 3'b010,
    SecBlue  = 3'b100
  } sector_e;

  typedef struct packed {
    logic    valid;
    sector_e sector;
    chan_t   max;
    chan_t   min;
    chan_t   pos;
    chan_t   negop;
    chan_t   alpha;
  } front_t;

  typedef struct packed {
    logic              valid;
    sector_e           sector;
    logic              neg;
    logic              hue_zero;
    logic              sat_zero;
    logic [HueNW-1:0]  hue_rem;
    chan_t             delta;
    logic [HueQW-1:0]  hue_quo;
    logic [SatNW-1:0]  sat_rem;
    chan_t             max;
    logic [SatQW-1:0]  sat_quo;
    chan_t             alpha;
  } div_t;

endpackage

`default_nettype wire

/* rtl/core/r2h_if.sv */
// r2h_pix_if and r2h_hsv_if: valid/ready channels for rgba pixels and hsv results
// depends on r2h_pkg
`default_nettype none

interface r2h_pix_if;
  import r2h_pkg::*;

  logic  valid;
  logic  ready;
  chan_t red;
  chan_t green;
  chan_t blue;
  chan_t alpha;

  modport source (output valid, output red, output green, output blue, output alpha,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  output ready);
endinterface

interface r2h_hsv_if;
  import r2h_pkg::*;

  logic  valid;
  logic  ready;
  hue_t  hue;
  chan_t saturation;
  chan_t brightness;
  chan_t alpha_out;

  modport source (output valid, output hue, output saturation, output brightness,
                  output alpha_out, input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  input alpha_out, output ready);
endinterface

`default_nettype wire

/* rtl/core/rgb_to_hsv_converter.sv */
// rgb_to_hsv_converter: pipelined rgba to hsv conversion, one pixel per transaction
// depends on r2h_pkg, r2h_pix_if and r2h_hsv_if
// stages: front register, dividend register, the 10-stage restoring hue divider
// (one quotient bit per stage) and the output register
// throughput: one transaction per cycle while hsv_o.ready is high; stalled stages fill bubbles upstream
// reset: asynchronous, active low, clears every stage valid bit
`default_nettype none

module rgb_to_hsv_converter (
  input  logic         clk_i,
  input  logic         rst_ni,
  r2h_pix_if.sink      pix_i,
  r2h_hsv_if.source    hsv_o
);
  import r2h_pkg::*;

  front_t             a_d;
  front_t             a_q;
  div_t               b_d;
  div_t               pipe_q [HueQW+1];
  logic [HueQW:0]     en_pipe;
  logic               en_a;
  logic               en_out;

  logic               out_valid_q;
  hue_t               hue_d;
  hue_t               hue_q;
  chan_t              sat_d;
  chan_t              sat_q;
  chan_t              bright_q;
  chan_t              alpha_q;

  chan_t              abs_diff;
  logic               diff_neg;
  chan_t              delta;
  hue_t               offset;
  logic [HueW:0]      hue_sub;

  // enable chain, bubbles collapse toward the output
  assign en_out           = !out_valid_q || hsv_o.ready;
  assign en_pipe[HueQW]   = !pipe_q[HueQW].valid || en_out;
  for (genvar k = 0; k < HueQW; k++) begin : g_en
    assign en_pipe[k] = !pipe_q[k].valid || en_pipe[k+1];
  end
  assign en_a        = !a_q.valid || en_pipe[0];
  assign pix_i.ready = en_a;

  // front: sector, max, min and difference operands
  always_comb begin
    a_d       = '0;
    a_d.valid = pix_i.valid;
    a_d.alpha = pix_i.alpha;
    if (pix_i.red >= pix_i.green && pix_i.red >= pix_i.blue) begin
      a_d.sector = SecRed;
      a_d.max    = pix_i.red;
      a_d.pos    = pix_i.green;
      a_d.negop  = pix_i.blue;
    end else if (pix_i.green >= pix_i.blue) begin
      a_d.sector = SecGreen;
      a_d.max    = pix_i.green;
      a_d.pos    = pix_i.blue;
      a_d.negop  = pix_i.red;
    end else begin
      a_d.sector = SecBlue;
      a_d.max    = pix_i.blue;
      a_d.pos    = pix_i.red;
      a_d.negop  = pix_i.green;
    end
    if (pix_i.red <= pix_i.green && pix_i.red <= pix_i.blue) begin
      a_d.min = pix_i.red;
    end else if (pix_i.green <= pix_i.blue) begin
      a_d.min = pix_i.green;
    end else begin
      a_d.min = pix_i.blue;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
    end else if (en_a) begin
      a_q <= a_d;
    end
  end

  // delta, magnitude of the difference and both dividends
  always_comb begin
    diff_neg = a_q.pos < a_q.negop;
    abs_diff = diff_neg ? (a_q.negop - a_q.pos) : (a_q.pos - a_q.negop);
    delta    = a_q.max - a_q.min;

    b_d          = '0;
    b_d.valid    = a_q.valid;
    b_d.sector   = a_q.sector;
    b_d.neg      = diff_neg;
    b_d.hue_zero = (delta == '0);
    b_d.sat_zero = (a_q.max == '0);
    b_d.hue_rem  = HueNW'(abs_diff) * HueNW'(HueScale);
    b_d.delta    = delta;
    b_d.sat_rem  = SatNW'(delta) * SatNW'(ChanFull);
    b_d.max      = a_q.max;
    b_d.alpha    = a_q.alpha;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_q[0] <= '0;
    end else if (en_pipe[0]) begin
      pipe_q[0] <= b_d;
    end
  end

  // restoring division, one hue quotient bit per stage, one saturation quotient bit in the last SatQW stages
  for (genvar k = 0; k < HueQW; k++) begin : g_div
    localparam int unsigned BitIdx = HueQW - 1 - k;
    logic [HueNW-1:0] hue_trial;
    logic [SatNW-1:0] sat_trial;
    div_t             step_d;

    always_comb begin
      step_d    = pipe_q[k];
      hue_trial = HueNW'(pipe_q[k].delta) << BitIdx;
      sat_trial = SatNW'(pipe_q[k].max) << BitIdx;
      if (pipe_q[k].hue_rem >= hue_trial) begin
        step_d.hue_rem         = pipe_q[k].hue_rem - hue_trial;
        step_d.hue_quo[BitIdx] = 1'b1;
      end
      if (BitIdx < SatQW) begin
        if (pipe_q[k].sat_rem >= sat_trial) begin
          step_d.sat_rem = pipe_q[k].sat_rem - sat_trial;
          step_d.sat_quo[BitIdx % SatQW] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pipe_q[k+1] <= '0;
      end else if (en_pipe[k+1]) begin
        pipe_q[k+1] <= step_d;
      end
    end
  end

  // sector offset, sign and wrap
  always_comb begin
    case (pipe_q[HueQW].sector)
      SecRed:   offset = HueRedOffset;
      SecGreen: offset = HueGreenOffset;
      SecBlue:  offset = HueBlueOffset;
      default:  offset = HueRedOffset;
    endcase
    hue_sub = {1'b0, offset} - (HueW+1)'(pipe_q[HueQW].hue_quo);
    if (pipe_q[HueQW].hue_zero) begin
      hue_d = '0;
    end else if (!pipe_q[HueQW].neg) begin
      hue_d = offset + HueW'(pipe_q[HueQW].hue_quo);
    end else if (hue_sub[HueW]) begin
      hue_d = HueW'(hue_sub + {1'b0, HueFullTurn});
    end else begin
      hue_d = hue_sub[HueW-1:0];
    end
    sat_d = pipe_q[HueQW].sat_zero ? '0 : pipe_q[HueQW].sat_quo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_out) begin
      out_valid_q <= pipe_q[HueQW].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      hue_q    <= hue_d;
      sat_q    <= sat_d;
      bright_q <= pipe_q[HueQW].max;
      alpha_q  <= pipe_q[HueQW].alpha;
    end
  end

  assign hsv_o.valid      = out_valid_q;
  assign hsv_o.hue        = hue_q;
  assign hsv_o.saturation = sat_q;
  assign hsv_o.brightness = bright_q;
  assign hsv_o.alpha_out  = alpha_q;

endmodule

`default_nettype wire

/* rtl/core/r2h_checker.sv */
// r2h_checker: port-level checks of the rgb to hsv converter, bound to the top level
// depends on r2h_pkg and rgb_to_hsv_converter
`default_nettype none

module r2h_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  r2h_pkg::hue_t  hue_i,
  input  r2h_pkg::chan_t saturation_i,
  input  r2h_pkg::chan_t brightness_i,
  input  r2h_pkg::chan_t alpha_out_i
);
  import r2h_pkg::*;

  // hue stays within one turn
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (hue_i < HueFullTurn))
    else $error("hue out of range");

  // black pixel has no saturation
  a_black_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && brightness_i == '0) |-> (saturation_i == '0))
    else $error("saturation nonzero for black pixel");

  // no saturation means grey, grey has hue zero
  a_grey_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && saturation_i == '0) |-> (hue_i == '0))
    else $error("hue nonzero for grey pixel");

  // stalled transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(hue_i) && $stable(saturation_i) &&
       $stable(brightness_i) && $stable(alpha_out_i)))
    else $error("output transaction changed while stalled");

endmodule

bind rgb_to_hsv_converter r2h_checker u_r2h_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (hsv_o.valid),
  .out_ready_i  (hsv_o.ready),
  .hue_i        (hsv_o.hue),
  .saturation_i (hsv_o.saturation),
  .brightness_i (hsv_o.brightness),
  .alpha_out_i  (hsv_o.alpha_out)
);

`default_nettype wire
